>>> sv/bmap_pkg.sv
package bmap_pkg;

  // Mapper configuration
  localparam int ROM_BANK_BITS   = 4;
  localparam int SRAM_HALF_BYTES = 4096;   // power of two, 1024..4096

  // Widths of the access fields
  localparam int ADDR_W     = 15;
  localparam int DATA_W     = 8;
  localparam int ROM_ADDR_W = 17;
  localparam int PAGE_W     = 2;
  localparam int OFFS_W     = 13;
  localparam int BANK_W     = 4;
  localparam int NUM_PAGES  = 4;

  // SRAM geometry: two halves of SRAM_HALF_BYTES each
  localparam int SRAM_HALF_AW = $clog2(SRAM_HALF_BYTES);
  localparam int SRAM_AW      = SRAM_HALF_AW + 1;
  localparam int SRAM_DEPTH   = 2 * SRAM_HALF_BYTES;

  // Bank field is data[3:0] narrowed to ROM_BANK_BITS
  localparam logic [BANK_W-1:0] BANK_MASK = BANK_W'((1 << ROM_BANK_BITS) - 1);

  // Mapping-register data bits
  localparam int MAP_SRAM_BIT = 4;
  localparam int MAP_HALF_BIT = 5;

  // Page without mapping registers, and page holding the SRAM write enable and the SRAM write window
  localparam logic [PAGE_W-1:0] PAGE_ZERO = 2'd0;
  localparam logic [PAGE_W-1:0] PAGE_LAST = 2'd3;

  localparam logic [DATA_W-1:0] SRAM_FILL = 8'hFF;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic               en;
    logic [SRAM_AW-1:0] addr;
    logic [DATA_W-1:0]  data;
  } sram_wr_t;

  typedef struct packed {
    logic               en;
    logic [SRAM_AW-1:0] addr;
  } sram_rd_t;

endpackage

>>> sv/bmap_if.sv
interface bmap_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [bmap_pkg::ADDR_W-1:0]  address;
  logic [bmap_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

interface bmap_out_if;
  logic                            valid;
  logic                            ready;
  logic                            from_sram;
  logic [bmap_pkg::ROM_ADDR_W-1:0] rom_address;
  logic [bmap_pkg::DATA_W-1:0]     read_data;

  modport source (output valid, output from_sram, output rom_address, output read_data,
                  input ready);
  modport sink   (input valid, input from_sram, input rom_address, input read_data,
                  output ready);
endinterface

>>> sv/rom_bank_mapper_with_sram.sv
// Cartridge bank mapper for a 32KB window of four 8KB pages, with an 8KB
// battery SRAM split into two halves.
//
// in_ch  : one bus access per transfer (opcode, address, write_data).
// out_ch : one result per access (from_sram, rom_address, read_data).
//          Write accesses return an all-zero result.
//
// Latency: the result is registered and valid the cycle after the input transfer.
// Throughput: one access per cycle while out_ch.ready allows and the SRAM sweep is
// done; each access makes at most one SRAM read or write, and mapping registers
// update at the transfer edge so the next access already sees them.
//
// Reset: mapping registers clear (every page maps ROM bank 0, SRAM write
// disabled). The SRAM is then swept to 0xFF, one byte per cycle, over all
// 2 * SRAM_HALF_BYTES (8192) bytes; in_ch.ready stays low meanwhile.
//
// Stall: a single output register holds the result while out_ch.ready is
// low; in_ch.ready follows it, so a new access is taken in the same cycle
// the pending result drains.
module rom_bank_mapper_with_sram (
  input  logic              clk,
  input  logic              rst_n,
  bmap_in_if.sink           in_ch,
  bmap_out_if.source        out_ch
);

  // mapping state, flip-flops (page zero entries stay at reset)
  logic [bmap_pkg::BANK_W-1:0] page_rom_bank_r    [bmap_pkg::NUM_PAGES];
  logic                        page_sram_mapped_r [bmap_pkg::NUM_PAGES];
  logic                        page_sram_half_r   [bmap_pkg::NUM_PAGES];
  logic                        sram_wen_r;
  logic                        sram_wr_half_r;

  // result register
  logic                            out_valid_r;
  logic                            from_sram_r;
  logic [bmap_pkg::ROM_ADDR_W-1:0] rom_address_r;
  logic                            out_valid_nxt;

  logic                            accept;
  logic                            is_wr;
  logic [bmap_pkg::PAGE_W-1:0]     page;
  logic [bmap_pkg::OFFS_W-1:0]     offs;
  logic                            map_wr;
  logic                            sram_wr_hit;
  logic                            sram_rd_hit;
  logic                            data_sram;
  logic                            data_half;
  logic                            clr_busy;
  logic [bmap_pkg::DATA_W-1:0]     sram_rdata;

  bmap_pkg::sram_wr_t              sram_wr;
  bmap_pkg::sram_rd_t              sram_rd;

  assign page      = in_ch.address[bmap_pkg::ADDR_W-1 -: bmap_pkg::PAGE_W];
  assign offs      = in_ch.address[bmap_pkg::OFFS_W-1:0];
  assign is_wr     = (in_ch.opcode == bmap_pkg::OP_WRITE);
  assign data_sram = in_ch.write_data[bmap_pkg::MAP_SRAM_BIT];
  assign data_half = in_ch.write_data[bmap_pkg::MAP_HALF_BIT];

  assign in_ch.ready = !clr_busy && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // mapping register hit: offset 0 of pages 1..3
  assign map_wr = is_wr && (page != bmap_pkg::PAGE_ZERO) && (offs == '0);

  // SRAM write window is the upper 4KB of the last page (0x7000..0x7FFF)
  assign sram_wr_hit = is_wr && !map_wr && sram_wen_r
                       && (page == bmap_pkg::PAGE_LAST)
                       && in_ch.address[bmap_pkg::OFFS_W-1];

  assign sram_rd_hit = !is_wr && page_sram_mapped_r[page];

  // each half mirrors across its page: low offset bits only
  always_comb begin
    sram_wr.en   = accept && sram_wr_hit;
    sram_wr.addr = {sram_wr_half_r, in_ch.address[bmap_pkg::SRAM_HALF_AW-1:0]};
    sram_wr.data = in_ch.write_data;
    sram_rd.en   = accept && sram_rd_hit;
    sram_rd.addr = {page_sram_half_r[page], offs[bmap_pkg::SRAM_HALF_AW-1:0]};
  end

  bmap_sram u_sram (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (sram_wr),
    .rd    (sram_rd),
    .rdata (sram_rdata),
    .busy  (clr_busy)
  );

  // mapping register updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bmap_pkg::NUM_PAGES; i++) begin
        page_rom_bank_r[i]    <= '0;
        page_sram_mapped_r[i] <= 1'b0;
        page_sram_half_r[i]   <= 1'b0;
      end
      sram_wen_r     <= 1'b0;
      sram_wr_half_r <= 1'b0;
    end else if (accept && map_wr) begin
      if (page == bmap_pkg::PAGE_LAST) begin
        sram_wen_r <= data_sram;
      end
      if (data_sram) begin
        page_sram_mapped_r[page] <= 1'b1;
        page_sram_half_r[page]   <= data_half;
        sram_wr_half_r           <= data_half;
      end else begin
        // ROM bank changes only on a ROM mapping; SRAM mapping keeps it
        page_sram_mapped_r[page] <= 1'b0;
        page_rom_bank_r[page]    <= in_ch.write_data[bmap_pkg::BANK_W-1:0]
                                    & bmap_pkg::BANK_MASK;
      end
    end
  end

  // output register / handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      from_sram_r <= sram_rd_hit;
      if (!is_wr && !page_sram_mapped_r[page]) begin
        rom_address_r <= {page_rom_bank_r[page], offs};
      end else begin
        rom_address_r <= '0;
      end
    end
  end

  // SRAM read data is registered in the RAM and held until the next read
  assign out_ch.valid       = out_valid_r;
  assign out_ch.from_sram   = from_sram_r;
  assign out_ch.rom_address = rom_address_r;
  assign out_ch.read_data   = from_sram_r ? sram_rdata : '0;

endmodule

>>> sv/bmap_sram.sv
module bmap_sram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmap_pkg::sram_wr_t            wr,
  input  bmap_pkg::sram_rd_t            rd,
  output logic [bmap_pkg::DATA_W-1:0]   rdata,
  output logic                          busy
);

  logic [bmap_pkg::DATA_W-1:0]  mem [bmap_pkg::SRAM_DEPTH];
  logic [bmap_pkg::DATA_W-1:0]  rdata_r;
  logic                         clr_r;
  logic [bmap_pkg::SRAM_AW-1:0] clr_addr_r;
  logic                         clr_nxt;
  logic [bmap_pkg::SRAM_AW-1:0] clr_addr_nxt;

  // fill sweep after reset: one entry per cycle
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= bmap_pkg::SRAM_FILL;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_r <= mem[rd.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_r;

endmodule
